// ===== hdl/isfc_pkg.sv =====
// shared types, constants and crc helper for the imu spi frame codec
package isfc_pkg;

	localparam int NUM_DEVICES = 2;

	localparam logic [7:0] CRC_POLY   = 8'h1D;
	localparam logic [7:0] CRC_INIT   = 8'hFF;
	localparam logic [7:0] CRC_XOROUT = 8'hFF;

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_CHECK = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK            = 2'd0,
		STATUS_CRC_ERR       = 2'd1,
		STATUS_ADDR_MISMATCH = 2'd2,
		STATUS_NO_CMD        = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        device;
		logic [4:0]  reg_address;
		logic [15:0] write_data;
		logic [31:0] rx_frame;
	} req_t;

	typedef struct packed {
		logic [31:0]        tx_frame;
		status_t            resp_status;
		logic [4:0]         resp_address;
		logic signed [15:0] resp_data;
		logic signed [15:0] resp_data_negated;
	} rsp_t;

	// one byte through the crc register, msb first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/imu_spi_frame_codec.sv =====
// top level of the imu spi frame codec: command frame builder and response checker
//
// One request channel (req, req_valid, req_stall) and one result channel
// (rsp, rsp_valid, rsp_stall). Every request beat gives exactly one result beat.
// A read or write request returns the 32-bit command frame with its crc and
// records the register address for that device. A check request verifies a
// received frame: crc first, then the address against the last command to
// that device, then that the device was ever commanded; it returns the
// signed data and its saturating negation.
// A beat is registered on input, processed by combinational logic (the crc
// over three bytes sets the path) and registered on output; while rsp_stall
// is low, the pipeline sustains one beat per cycle from request to result.
// When the receiver stalls, the result stays held and the input register
// still takes one more beat; req_stall rises only with both registers full.
// Reset clears both pipeline valids, the recorded addresses and the
// per-device command-seen flags.
module imu_spi_frame_codec (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  isfc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output isfc_pkg::rsp_t rsp
);
	import isfc_pkg::*;

	logic       valid_s1;
	req_t       req_s1;
	logic       valid_s2;
	rsp_t       rsp_s2;
	rsp_t       rsp_next;
	logic       adv;

	logic [4:0]             last_addr_q [NUM_DEVICES];
	logic [NUM_DEVICES-1:0] seen_q;

	logic        is_cmd;
	logic        is_check;
	logic        dev_ok;
	logic [4:0]  stored_addr;
	logic        stored_seen;
	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [7:0]  b2;
	logic [23:0] crc_data;
	logic [7:0]  crc;
	logic [4:0]  raddr;
	logic [15:0] rdata;

	assign adv       = !valid_s2 || !rsp_stall;
	assign req_stall = valid_s1 && !adv;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	assign is_cmd   = (req_s1.mode == MODE_READ) || (req_s1.mode == MODE_WRITE);
	assign is_check = (req_s1.mode == MODE_CHECK);
	assign dev_ok   = int'(req_s1.device) < NUM_DEVICES;

	always_comb begin
		stored_addr = '0;
		stored_seen = 1'b0;
		for (int i = 0; i < NUM_DEVICES; i++) begin
			if (dev_ok && int'(req_s1.device) == i) begin
				stored_addr = last_addr_q[i];
				stored_seen = seen_q[i];
			end
		end
	end

	always_comb begin
		b0 = {req_s1.mode == MODE_WRITE, req_s1.reg_address, 2'b00};
		if (req_s1.mode == MODE_WRITE) begin
			b1 = req_s1.write_data[15:8];
			b2 = req_s1.write_data[7:0];
		end else begin
			b1 = '0;
			b2 = '0;
		end
		crc_data = is_check ? req_s1.rx_frame[31:8] : {b0, b1, b2};
	end

	isfc_crc8 u_crc (
		.data (crc_data),
		.crc  (crc)
	);

	assign raddr = req_s1.rx_frame[30:26];
	assign rdata = req_s1.rx_frame[23:8];

	always_comb begin
		rsp_next = '0;
		if (is_cmd) begin
			rsp_next.tx_frame = {b0, b1, b2, crc};
		end else if (is_check) begin
			rsp_next.resp_address = raddr;
			rsp_next.resp_data    = rdata;
			if (rdata == 16'h8000) begin
				rsp_next.resp_data_negated = 16'sh7FFF;
			end else begin
				rsp_next.resp_data_negated = -$signed(rdata);
			end
			if (crc != req_s1.rx_frame[7:0]) begin
				rsp_next.resp_status = STATUS_CRC_ERR;
			end else if (raddr != stored_addr) begin
				rsp_next.resp_status = STATUS_ADDR_MISMATCH;
			end else if (!stored_seen) begin
				rsp_next.resp_status = STATUS_NO_CMD;
			end else begin
				rsp_next.resp_status = STATUS_OK;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			rsp_s2 <= rsp_next;
		end
	end

	// per-device command memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DEVICES; i++) begin
				last_addr_q[i] <= '0;
			end
			seen_q <= '0;
		end else if (valid_s1 && adv && is_cmd) begin
			for (int i = 0; i < NUM_DEVICES; i++) begin
				if (dev_ok && int'(req_s1.device) == i) begin
					last_addr_q[i] <= req_s1.reg_address;
					seen_q[i]      <= 1'b1;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2 && rsp_stall))
		else $error("input stalled with room in the pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		(seen_q & ~$past(seen_q)) == '0 || (valid_s1 && is_cmd) || $past(valid_s1))
		else $error("command-seen flag set without a command");

	assert property (@(posedge clk) disable iff (!arst_n)
		(~seen_q & $past(seen_q)) == '0)
		else $error("command-seen flag cleared outside reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rsp_s2.tx_frame != '0) |->
		(rsp_s2.resp_status == STATUS_OK && rsp_s2.resp_data == '0 &&
		 rsp_s2.resp_address == '0))
		else $error("command beat carries response fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv) |=> valid_s2)
		else $error("beat lost between input and result registers");

endmodule

// ===== hdl/isfc_crc8.sv =====
// crc-8 sae j1850 over the first three bytes of a frame
module isfc_crc8 (
	input  logic [23:0] data,
	output logic [7:0]  crc
);
	import isfc_pkg::*;

	logic [7:0] c0;
	logic [7:0] c1;
	logic [7:0] c2;

	always_comb begin
		c0  = crc8_byte(CRC_INIT, data[23:16]);
		c1  = crc8_byte(c0, data[15:8]);
		c2  = crc8_byte(c1, data[7:0]);
		crc = c2 ^ CRC_XOROUT;
	end

endmodule
